[sv/swam_pkg.sv]
package swam_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int LETTER_W     = 5;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [LETTER_W-1:0] letter;
  } item_t;

  typedef struct packed {
    logic window_match;
    logic found_any;
    logic pattern_overflow;
  } result_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_CLEAR,
    K_LOAD,
    K_DROP,
    K_TEXT,
    K_TEXT_EMPTY
  } kind_t;

endpackage

[sv/swam_if.sv]
interface swam_item_if;
  import swam_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swam_result_if;
  import swam_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/swam_ram.sv]
module swam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write to the same address return the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[sv/sliding_window_anagram_match_top.sv]
// An accepted transaction is registered in stage 1 and then in the result register,
// which holds it until taken. Throughput: one transaction per cycle while the result
// side does not stall; the count update is combinational and the letter ring RAM read is registered.
// Reset (rst, synchronous, active high) clears counts, pointers, flags and
// handshake state at once; the ring RAM is not cleared, and its read data is only
// used for entries written since the last clear.
module sliding_window_anagram_match_top #(
  parameter int MAX_LEN  = swam_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = swam_pkg::ALPHABET_DEF
) (
  input logic           clk,
  input logic           rst,
  swam_item_if.sink     item,
  swam_result_if.source result
);
  import swam_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // accept side
  logic [CW-1:0]       pattern_length;
  logic [AW-1:0]       ring_pointer;
  logic                item_acc;
  logic                letter_ok;
  kind_t               kind;
  logic                ring_we;
  logic [CW-1:0]       ptr_ext;
  logic [CW-1:0]       old_idx;
  logic [LETTER_W-1:0] ring_rdata;

  // stage 1
  logic                s1_valid;
  kind_t               s1_kind;
  logic [LETTER_W-1:0] s1_letter;
  logic [CW-1:0]       s1_plen;
  logic                s2_go;

  // count state
  logic [CW-1:0] pattern_counts [ALPHABET];
  logic [CW-1:0] window_counts  [ALPHABET];
  logic [CW-1:0] pattern_counts_next [ALPHABET];
  logic [CW-1:0] window_counts_next  [ALPHABET];
  logic [CW-1:0] wc_ev [ALPHABET];
  logic [CW-1:0] matched_total, matched_total_next;
  logic [CW-1:0] text_seen, text_seen_next;
  logic          found_flag, found_flag_next;
  logic          overflow_flag, overflow_flag_next;
  logic          match;

  logic [ALPHABET-1:0] sel_c, sel_o, gt, pos, lt_ev;
  logic [LETTER_W-1:0] old_letter;
  logic                evict, dec, inc_text, inc_load;

  assign item_acc  = item.valid && item.ready;
  assign letter_ok = 32'(item.data.letter) < ALPHABET;
  assign s2_go     = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s2_go;

  always_comb begin
    kind = K_NOP;
    case (item.data.op)
      OP_CLEAR: kind = K_CLEAR;
      OP_LOAD: begin
        if (letter_ok) begin
          kind = (pattern_length < CW'(MAX_LEN)) ? K_LOAD : K_DROP;
        end
      end
      OP_TEXT: begin
        if (letter_ok) begin
          kind = (pattern_length != '0) ? K_TEXT : K_TEXT_EMPTY;
        end
      end
      default: kind = K_NOP;
    endcase
  end

  assign ptr_ext = CW'(ring_pointer);
  assign old_idx = (ptr_ext >= pattern_length) ? ptr_ext - pattern_length
                                               : CW'(MAX_LEN) - pattern_length + ptr_ext;
  assign ring_we = item_acc && (kind == K_TEXT);

  swam_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pointer),
    .wdata (item.data.letter),
    .re    (item_acc),
    .raddr (old_idx[AW-1:0]),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      ring_pointer   <= '0;
    end else if (item_acc) begin
      if (kind == K_CLEAR) begin
        pattern_length <= '0;
        ring_pointer   <= '0;
      end else if (kind == K_LOAD) begin
        pattern_length <= pattern_length + 1'b1;
      end else if (kind == K_TEXT) begin
        ring_pointer <= (ring_pointer == AW'(MAX_LEN - 1)) ? '0 : ring_pointer + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_acc) begin
      s1_valid <= 1'b1;
    end else if (s2_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_kind   <= kind;
      s1_letter <= item.data.letter;
      s1_plen   <= pattern_length;
    end
  end

  // count update, one lane per letter
  assign old_letter = (32'(ring_rdata) < ALPHABET) ? ring_rdata : '0;
  assign evict      = (s1_kind == K_TEXT) && (text_seen >= s1_plen);

  always_comb begin
    for (int l = 0; l < ALPHABET; l++) begin
      sel_c[l] = 32'(s1_letter) == l;
      sel_o[l] = 32'(old_letter) == l;
      gt[l]    = window_counts[l] > pattern_counts[l];
      pos[l]   = window_counts[l] != '0;
      wc_ev[l] = window_counts[l] - CW'(evict && sel_o[l] && pos[l]);
      lt_ev[l] = wc_ev[l] < pattern_counts[l];
    end
  end

  assign dec      = evict && (|(sel_o & pos & ~gt)) && (matched_total != '0);
  assign inc_text = |(sel_c & lt_ev);
  assign inc_load = |(sel_c & gt);

  always_comb begin
    for (int l = 0; l < ALPHABET; l++) begin
      pattern_counts_next[l] = pattern_counts[l];
      window_counts_next[l]  = window_counts[l];
    end
    matched_total_next = matched_total;
    text_seen_next     = text_seen;
    found_flag_next    = found_flag;
    overflow_flag_next = overflow_flag;
    match              = 1'b0;
    case (s1_kind)
      K_CLEAR: begin
        for (int l = 0; l < ALPHABET; l++) begin
          pattern_counts_next[l] = '0;
          window_counts_next[l]  = '0;
        end
        matched_total_next = '0;
        text_seen_next     = '0;
        found_flag_next    = 1'b0;
        overflow_flag_next = 1'b0;
      end
      K_LOAD: begin
        for (int l = 0; l < ALPHABET; l++) begin
          pattern_counts_next[l] = pattern_counts[l] + CW'(sel_c[l]);
        end
        matched_total_next = matched_total + CW'(inc_load);
      end
      K_DROP: overflow_flag_next = 1'b1;
      K_TEXT: begin
        for (int l = 0; l < ALPHABET; l++) begin
          window_counts_next[l] = wc_ev[l] + CW'(sel_c[l]);
        end
        matched_total_next = matched_total - CW'(dec) + CW'(inc_text);
        text_seen_next     = text_seen - CW'(evict) + 1'b1;
        match = (text_seen_next == s1_plen) && (matched_total_next == s1_plen);
        found_flag_next = found_flag | match;
      end
      K_TEXT_EMPTY: begin
        match           = 1'b1;
        found_flag_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < ALPHABET; l++) begin
        pattern_counts[l] <= '0;
        window_counts[l]  <= '0;
      end
      matched_total <= '0;
      text_seen     <= '0;
      found_flag    <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (s2_go) begin
      for (int l = 0; l < ALPHABET; l++) begin
        pattern_counts[l] <= pattern_counts_next[l];
        window_counts[l]  <= window_counts_next[l];
      end
      matched_total <= matched_total_next;
      text_seen     <= text_seen_next;
      found_flag    <= found_flag_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      result.data.window_match     <= match;
      result.data.found_any        <= found_flag_next;
      result.data.pattern_overflow <= overflow_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_total_le_seen: assert property (@(posedge clk) disable iff (rst)
    matched_total <= text_seen)
    else $error("matched total exceeds window fill");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(ring_pointer) < MAX_LEN)
    else $error("ring pointer out of range");

  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    s2_go |=> result.valid)
    else $error("stage 1 advanced without a result");

  a_match_sets_found: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.window_match |-> result.data.found_any)
    else $error("match reported without found flag");
`endif

endmodule

[sim/swam_checker.sv]
`timescale 1ns / 100ps
module swam_checker (
  input  logic   clk,
  input  logic   rst,
  swam_item_if   item,
  swam_result_if result,
  output int     fail_count,
  output int     pending
);
  import swam_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN_DEF) + 1;
  localparam int PTR_W = $clog2(MAX_LEN_DEF);

  logic [CNT_W-1:0]    pat_cnt [ALPHABET_DEF];
  logic [CNT_W-1:0]    win_cnt [ALPHABET_DEF];
  logic [CNT_W-1:0]    overlap;
  logic [CNT_W-1:0]    pat_len;
  logic [CNT_W-1:0]    win_fill;
  logic [LETTER_W-1:0] ring [MAX_LEN_DEF];
  logic [PTR_W-1:0]    wr_ptr;
  logic                found;
  logic                ovf;

  result_t expected_status [$];
  int      errs = 0;

  task automatic clear_matcher();
    for (int i = 0; i < ALPHABET_DEF; i++) begin
      pat_cnt[i] = '0;
      win_cnt[i] = '0;
    end
    overlap  = '0;
    pat_len  = '0;
    win_fill = '0;
    wr_ptr   = '0;
    found    = 1'b0;
    ovf      = 1'b0;
  endtask

  task automatic slide_in(input logic [LETTER_W-1:0] c, output logic hit);
    int                  oldest;
    logic [LETTER_W-1:0] o;
    if (pat_len == 0) begin
      hit = 1'b1;
    end else begin
      if (win_fill >= pat_len) begin
        oldest = (int'(wr_ptr) >= int'(pat_len)) ? int'(wr_ptr) - int'(pat_len)
                                                 : int'(wr_ptr) + MAX_LEN_DEF - int'(pat_len);
        o = ring[oldest];
        if (win_cnt[o] > 0) begin
          if (win_cnt[o] <= pat_cnt[o] && overlap > 0) overlap--;
          win_cnt[o]--;
        end
        win_fill--;
      end
      if (win_cnt[c] < pat_cnt[c]) overlap++;
      win_cnt[c]++;
      ring[wr_ptr] = c;
      wr_ptr = (int'(wr_ptr) == MAX_LEN_DEF - 1) ? '0 : wr_ptr + 1'b1;
      win_fill++;
      hit = (win_fill == pat_len) && (overlap == pat_len);
    end
  endtask

  task automatic step_matcher(input item_t it, output result_t r);
    logic hit;
    hit = 1'b0;
    case (it.op)
      OP_CLEAR: begin
        clear_matcher();
      end
      OP_LOAD: begin
        if (it.letter < ALPHABET_DEF) begin
          if (pat_len >= MAX_LEN_DEF) begin
            ovf = 1'b1;
          end else begin
            if (win_cnt[it.letter] > pat_cnt[it.letter]) overlap++;
            pat_cnt[it.letter]++;
            pat_len++;
          end
        end
      end
      OP_TEXT: begin
        if (it.letter < ALPHABET_DEF) begin
          slide_in(it.letter, hit);
          if (hit) found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.window_match     = hit;
    r.found_any        = found;
    r.pattern_overflow = ovf;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      clear_matcher();
      expected_status.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = result.data;
        if (expected_status.size() == 0) begin
          $error("result transaction with no outstanding item");
          errs++;
        end else begin
          want = expected_status.pop_front();
          if (got.window_match !== want.window_match) begin
            $error("window_match: expected %0b, got %0b", want.window_match, got.window_match);
            errs++;
          end
          if (got.found_any !== want.found_any) begin
            $error("found_any: expected %0b, got %0b", want.found_any, got.found_any);
            errs++;
          end
          if (got.pattern_overflow !== want.pattern_overflow) begin
            $error("pattern_overflow: expected %0b, got %0b",
                   want.pattern_overflow, got.pattern_overflow);
            errs++;
          end
        end
      end
      if (item.valid && item.ready) begin
        step_matcher(item.data, want);
        expected_status.push_back(want);
      end
    end
    fail_count <= errs;
    pending    <= expected_status.size();
  end

endmodule

[sim/tb_sliding_window_anagram_match_top.sv]
`timescale 1ns / 100ps
module tb_sliding_window_anagram_match_top;
  import swam_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int RANDOM_ITEMS        = 1060;
  localparam int HOLD_START          = 400;
  localparam int HOLD_CYCLES         = 300;
  localparam int DRAIN_CYCLES        = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   items_counted = 0;
  bit   no_gaps = 1'b0;

  swam_item_if   item_ch ();
  swam_result_if result_ch ();

  sliding_window_anagram_match_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  swam_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [LETTER_W-1:0] pick_letter(input int base, input int span);
    return LETTER_W'(base + $urandom_range(0, span - 1));
  endfunction

  function automatic logic [LETTER_W-1:0] any_letter(input int lo);
    return LETTER_W'($urandom_range(lo, 31));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [LETTER_W-1:0] letter);
    int    gap;
    item_t it;
    gap = no_gaps ? 0 : pick_gap();
    it.op     = op;
    it.letter = letter;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (op == OP_CLEAR || (op != OP_UNUSED && letter < ALPHABET_DEF)) items_counted++;
  endtask

  task automatic random_sequence();
    int base;
    int span;
    int plen;
    int tlen;
    int roll;
    no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 99) < 85) send_item(OP_CLEAR, any_letter(0));
    if ($urandom_range(0, 9) == 0) begin
      base = 0;
      span = ALPHABET_DEF;
    end else begin
      span = $urandom_range(1, 4);
      base = $urandom_range(0, ALPHABET_DEF - span);
    end
    roll = $urandom_range(0, 99);
    if (roll < 15) plen = 0;
    else if (roll < 85) plen = $urandom_range(1, 6);
    else plen = $urandom_range(7, 40);
    repeat (plen) send_item(OP_LOAD, pick_letter(base, span));
    tlen = plen + $urandom_range(0, 2 * plen + 8);
    repeat (tlen) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) send_item(OP_UNUSED, any_letter(0));
      else if (roll < 4) send_item(OP_TEXT, any_letter(ALPHABET_DEF));
      else if (roll < 6) send_item(OP_LOAD, any_letter(0));
      else if (roll < 7) send_item(OP_CLEAR, any_letter(0));
      else send_item(OP_TEXT, pick_letter(base, span));
    end
  endtask

  initial begin
    int gap;
    int run;
    int cycles;
    bit held;
    held   = 1'b0;
    cycles = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // long backpressure once, sender keeps offering
      if (!held && cycles >= HOLD_START) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cycles += HOLD_CYCLES;
      end
      gap = pick_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        cycles += gap;
      end
      run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 10);
      result_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      cycles += run;
    end
  end

  initial begin
    int start;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_UNUSED, 5'd31);
    send_item(OP_TEXT, 5'd0);
    send_item(OP_TEXT, 5'd31);
    send_item(OP_LOAD, 5'd26);
    send_item(OP_LOAD, 5'd31);
    send_item(OP_CLEAR, 5'd31);
    send_item(OP_LOAD, 5'd0);
    send_item(OP_LOAD, 5'd25);
    send_item(OP_LOAD, 5'd0);
    send_item(OP_TEXT, 5'd25);
    send_item(OP_TEXT, 5'd0);
    send_item(OP_TEXT, 5'd0);
    send_item(OP_TEXT, 5'd0);
    send_item(OP_TEXT, 5'd25);
    send_item(OP_UNUSED, 5'd0);
    send_item(OP_LOAD, 5'd25);
    send_item(OP_TEXT, 5'd31);
    send_item(OP_TEXT, 5'd25);
    send_item(OP_CLEAR, 5'd0);
    send_item(OP_TEXT, 5'd25);
    send_item(OP_LOAD, 5'd25);
    send_item(OP_TEXT, 5'd24);
    send_item(OP_TEXT, 5'd25);

    start = items_counted;
    while (items_counted - start < RANDOM_ITEMS) random_sequence();

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/swam_pkg.sv
sv/swam_if.sv
sv/swam_ram.sv
sv/sliding_window_anagram_match_top.sv
sim/swam_checker.sv
sim/tb_sliding_window_anagram_match_top.sv
